>>> rtl/ascb_pkg.sv
// Addressed speed command bridge: shared types and constants.
// No dependencies; imported by every module of the block.
package ascb_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	// frame layout
	localparam int unsigned ECHO_LEN  = 7;
	localparam int unsigned CTRL_LEN  = 20;
	localparam logic [4:0]  LAST_IDX  = 5'(ECHO_LEN + CTRL_LEN - 1);

	localparam logic [7:0] ECHO_TAG   = 8'h04;
	localparam logic [7:0] CTRL_HDR0  = 8'h3E;
	localparam logic [7:0] CTRL_HDR1  = 8'h43;
	localparam logic [7:0] CTRL_HDR2  = 8'h0F;
	localparam logic [7:0] CTRL_HDR3  = 8'h52;
	localparam logic [7:0] CTRL_MODE  = 8'h01;
	// three mode bytes sit inside the checksummed span
	localparam logic [7:0] CTRL_SUM_BASE = 8'h03;

	// speed shaping: |x|*99/100 with x = 32*s equals floor(792*|s|/25)
	localparam logic [9:0]  SHAPE_MUL   = 10'd792;
	localparam logic [17:0] RECIP_25    = 18'd167773;  // ceil(2^22 / 25)
	localparam int unsigned RECIP_SHIFT = 22;

	// register indexes
	localparam logic [1:0] REG_PAN     = 2'd0;
	localparam logic [1:0] REG_TILT    = 2'd1;
	localparam logic [1:0] REG_ROLL    = 2'd2;
	localparam logic [1:0] REG_CENTRAL = 2'd3;

	typedef struct packed {
		logic [15:0] pan;
		logic [15:0] tilt;
		logic [15:0] roll;
	} addr_cfg_t;

	// bit0 pan, bit1 tilt, bit2 roll
	typedef struct packed {
		logic [7:0] speed;
		logic [2:0] sel;
	} cmd_t;

endpackage

>>> rtl/addressed_speed_command_bridge_top.sv
// Addressed speed command bridge, top level.
// Instantiates ascb_front, ascb_queue and ascb_back; holds the APB registers.
//
// Usage:
//  Input channel (in_valid/in_ready/rx_byte) takes one link word a cycle while
//  the four-entry command queue has room; in_ready drops only when it is full.
//  A word that completes a payload queues one command. The back end takes it,
//  runs the shaping steps (multiply, reciprocal divide, store update) and then
//  emits 27 words on the output channel (out_valid/out_ready): seven echo
//  words on link 0, then twenty control words on link 1, last_of_run set on
//  the final one. The back end takes the next command only after the last
//  word of a run is loaded. Words that complete nothing produce no output.
//  The output word sits in a register: while out_ready is low it holds and the
//  front keeps taking words until the queue fills.
//  Reset (arst_n low) loads the address registers with their defaults and
//  clears window, reception state, selects, stored speeds and the queue.
//  APB: registers pan, tilt, roll, central address at 0x0, 0x4, 0x8, 0xC,
//  low 16 bits of pwdata used; pready is tied high.
module addressed_speed_command_bridge_top #(
	parameter int unsigned MAX_PAYLOAD = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        link,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);
	import ascb_pkg::*;

	logic [15:0] pan_q, tilt_q, roll_q, central_q;
	logic        wr_en;
	addr_cfg_t   addr_cfg;
	logic        accept;
	logic        push, pop, q_empty, q_full;
	cmd_t        push_cmd, head_cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q     <= 16'd6392;
			tilt_q    <= 16'd18251;
			roll_q    <= 16'd25887;
			central_q <= 16'd10114;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_PAN:     pan_q     <= pwdata[15:0];
				REG_TILT:    tilt_q    <= pwdata[15:0];
				REG_ROLL:    roll_q    <= pwdata[15:0];
				REG_CENTRAL: central_q <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PAN:     prdata = {16'h0000, pan_q};
			REG_TILT:    prdata = {16'h0000, tilt_q};
			REG_ROLL:    prdata = {16'h0000, roll_q};
			REG_CENTRAL: prdata = {16'h0000, central_q};
			default:     prdata = '0;
		endcase
	end

	assign addr_cfg.pan  = pan_q;
	assign addr_cfg.tilt = tilt_q;
	assign addr_cfg.roll = roll_q;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	ascb_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.addr_cfg (addr_cfg),
		.push     (push),
		.cmd      (push_cmd)
	);

	ascb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	ascb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.central_addr (central_q),
		.q_empty      (q_empty),
		.q_head       (head_cmd),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.link         (link),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

endmodule

>>> rtl/ascb_front.sv
// Front end: address window match, payload counting, command completion.
// Depends on ascb_pkg; pushes completed commands into ascb_queue.
module ascb_front #(
	parameter int unsigned MAX_PAYLOAD = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  ascb_pkg::addr_cfg_t addr_cfg,
	output logic              push,
	output ascb_pkg::cmd_t    cmd
);
	import ascb_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2);

	logic [7:0]       win_hi_q, win_lo_q;
	logic             receiving_q;
	logic [7:0]       exp_len_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       pay0_q;
	logic [2:0]       sel_q;

	logic [15:0]      addr;
	logic [2:0]       match;
	logic [CNT_W-1:0] count_inc;
	logic             done;
	logic             runaway;
	logic [7:0]       speed;

	always_comb begin
		addr      = {win_hi_q, win_lo_q};
		match     = {addr == addr_cfg.roll, addr == addr_cfg.tilt, addr == addr_cfg.pan};
		count_inc = count_q + CNT_W'(1);
		done      = receiving_q && (8'(count_inc) == exp_len_q);
		runaway   = receiving_q && !done && (count_inc > CNT_W'(MAX_PAYLOAD));
		speed     = (count_q == '0) ? rx_byte : pay0_q;
	end

	assign push      = accept && done;
	assign cmd.speed = speed;
	assign cmd.sel   = sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_hi_q    <= '0;
			win_lo_q    <= '0;
			receiving_q <= 1'b0;
			exp_len_q   <= '0;
			count_q     <= '0;
			pay0_q      <= '0;
			sel_q       <= '0;
		end else if (accept) begin
			if (receiving_q) begin
				if (count_q == '0)
					pay0_q <= rx_byte;
				if (done) begin
					receiving_q <= 1'b0;
					count_q     <= '0;
					exp_len_q   <= '0;
					pay0_q      <= '0;
				end else if (runaway) begin
					receiving_q <= 1'b0;
					count_q     <= '0;
				end else begin
					count_q <= count_inc;
				end
			end
			// a match on the completing word starts a fresh reception
			sel_q <= (done ? 3'b000 : sel_q) | match;
			if (match != 3'b000) begin
				receiving_q <= 1'b1;
				exp_len_q   <= rx_byte;
				count_q     <= '0;
			end
			win_hi_q <= win_lo_q;
			win_lo_q <= rx_byte;
		end
	end

endmodule

>>> rtl/ascb_queue.sv
// Short command queue between the front and back ends.
// Depends on ascb_pkg for the entry type and depth.
module ascb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ascb_pkg::cmd_t wdata,
	input  logic           pop,
	output ascb_pkg::cmd_t rdata,
	output logic           empty,
	output logic           full
);
	import ascb_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   level_q;

	assign empty = (level_q == '0);
	assign full  = (level_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop && !empty)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push && !full, pop && !empty})
				2'b10:   level_q <= level_q + (QPTR_W+1)'(1);
				2'b01:   level_q <= level_q - (QPTR_W+1)'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

>>> rtl/ascb_back.sv
// Back end: speed shaping, axis speed store and frame emission.
// Depends on ascb_pkg; takes commands from ascb_queue.
module ascb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    central_addr,
	input  logic           q_empty,
	input  ascb_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           link,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);
	import ascb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_DIV,
		ST_UPD,
		ST_EMIT
	} state_t;

	state_t      state_q;
	cmd_t        cur_q;
	logic [16:0] prod_q;
	logic [15:0] shaped_q;
	logic [15:0] pan_q, tilt_q, roll_q;
	logic [7:0]  csum_q;
	logic [4:0]  idx_q;
	logic        out_valid_q, link_q, last_q;
	logic [7:0]  byte_q;

	logic [7:0]  mag;
	logic [34:0] recip_prod;
	logic [12:0] quot;
	logic [15:0] yabs, shaped;
	logic [15:0] pan_n, tilt_n, roll_n;
	logic [7:0]  csum_n;
	logic [7:0]  frame_byte;
	logic        load;

	always_comb begin
		mag        = cur_q.speed[7] ? 8'(-cur_q.speed) : cur_q.speed;
		recip_prod = 35'(prod_q) * 35'(RECIP_25);
		quot       = recip_prod[RECIP_SHIFT +: 13];
		yabs       = 16'(quot) + 16'd1;
		if (cur_q.speed == 8'd0)
			shaped = '0;
		else if (cur_q.speed[7])
			shaped = 16'(-yabs);
		else
			shaped = yabs;

		pan_n  = cur_q.sel[0] ? shaped_q : pan_q;
		tilt_n = cur_q.sel[1] ? shaped_q : tilt_q;
		roll_n = cur_q.sel[2] ? shaped_q : roll_q;
		csum_n = CTRL_SUM_BASE + roll_n[7:0] + roll_n[15:8] + tilt_n[7:0] + tilt_n[15:8]
			+ pan_n[7:0] + pan_n[15:8];
	end

	always_comb begin
		case (idx_q)
			5'd0:    frame_byte = central_addr[15:8];
			5'd1:    frame_byte = central_addr[7:0];
			5'd2:    frame_byte = ECHO_TAG;
			5'd3:    frame_byte = cur_q.speed;
			5'd7:    frame_byte = CTRL_HDR0;
			5'd8:    frame_byte = CTRL_HDR1;
			5'd9:    frame_byte = CTRL_HDR2;
			5'd10:   frame_byte = CTRL_HDR3;
			5'd11:   frame_byte = CTRL_MODE;
			5'd12:   frame_byte = CTRL_MODE;
			5'd13:   frame_byte = CTRL_MODE;
			5'd14:   frame_byte = roll_q[7:0];
			5'd15:   frame_byte = roll_q[15:8];
			5'd18:   frame_byte = tilt_q[7:0];
			5'd19:   frame_byte = tilt_q[15:8];
			5'd22:   frame_byte = pan_q[7:0];
			5'd23:   frame_byte = pan_q[15:8];
			5'd26:   frame_byte = csum_q;
			default: frame_byte = 8'h00;
		endcase
	end

	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign load        = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign link        = link_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			prod_q      <= '0;
			shaped_q    <= '0;
			pan_q       <= '0;
			tilt_q      <= '0;
			roll_q      <= '0;
			csum_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			link_q      <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_head;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					prod_q  <= 17'(mag) * 17'(SHAPE_MUL);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					shaped_q <= shaped;
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					pan_q   <= pan_n;
					tilt_q  <= tilt_n;
					roll_q  <= roll_n;
					csum_q  <= csum_n;
					idx_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						byte_q      <= frame_byte;
						link_q      <= (idx_q >= 5'(ECHO_LEN));
						last_q      <= (idx_q == LAST_IDX);
						if (idx_q == LAST_IDX)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/sv/ascb_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for the addressed speed command bridge: follows APB writes and
// accepted link words, predicts the echo and control words, compares them in order.
// Depends on ascb_pkg for frame constants and register indexes.
module ascb_frame_checker #(
	parameter int unsigned MAX_PAYLOAD = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        link,
	input  logic [7:0]  out_byte,
	input  logic        last_of_run,
	output int          fail_count,
	output int          words_due
);
	import ascb_pkg::*;

	localparam logic [15:0] PAN_DEFAULT     = 16'd6392;
	localparam logic [15:0] TILT_DEFAULT    = 16'd18251;
	localparam logic [15:0] ROLL_DEFAULT    = 16'd25887;
	localparam logic [15:0] CENTRAL_DEFAULT = 16'd10114;

	typedef struct packed {
		logic       link;
		logic [7:0] data;
		logic       last;
	} link_word_t;

	logic [15:0] cfg_pan, cfg_tilt, cfg_roll, cfg_central;
	logic [7:0]  win_old, win_new;
	logic        rx_active;
	logic [7:0]  len_due;
	logic [4:0]  pay_count;
	logic [7:0]  first_pay;
	logic [2:0]  axis_sel;
	logic [15:0] speed_pan, speed_tilt, speed_roll;
	link_word_t  frames_due[$];
	link_word_t  want;
	int          fails;
	int          word_no;

	// x = 32*s, x*99/100 truncated towards zero, then pushed one away from zero
	function automatic logic [15:0] deadzone_speed(input logic [7:0] raw);
		int s, x, y;
		s = $signed(raw);
		x = s * 32;
		if (x == 0)
			return 16'h0000;
		y = (x * 99) / 100;
		y = (x < 0) ? y - 1 : y + 1;
		return y[15:0];
	endfunction

	task automatic owe_word(input logic lnk, input logic [7:0] data, input logic last);
		link_word_t w;
		w.link = lnk;
		w.data = data;
		w.last = last;
		frames_due.push_back(w);
	endtask

	task automatic absorb_link_byte(input logic [7:0] b);
		logic [15:0] win;
		logic        done;
		logic [7:0]  spd;
		logic [2:0]  held_sel;
		logic [15:0] v;
		logic [7:0]  ctrl [CTRL_LEN];
		logic [7:0]  sum;
		win = {win_old, win_new};
		done = 1'b0;
		spd = 8'h00;
		held_sel = axis_sel;
		// payload step first, on the state left by the previous word
		if (rx_active) begin
			if (pay_count == 5'd0)
				first_pay = b;
			pay_count = pay_count + 5'd1;
			if ({3'b000, pay_count} == len_due) begin
				done = 1'b1;
				spd = first_pay;
				rx_active = 1'b0;
				pay_count = 5'd0;
				len_due = 8'h00;
				first_pay = 8'h00;
			end else if (pay_count > MAX_PAYLOAD) begin
				rx_active = 1'b0;
				pay_count = 5'd0;
			end
		end
		if (done)
			axis_sel = 3'b000;
		// address match uses the window before this word; selects are sticky
		if (win == cfg_pan || win == cfg_tilt || win == cfg_roll) begin
			if (win == cfg_pan)
				axis_sel[0] = 1'b1;
			if (win == cfg_tilt)
				axis_sel[1] = 1'b1;
			if (win == cfg_roll)
				axis_sel[2] = 1'b1;
			rx_active = 1'b1;
			len_due = b;
			pay_count = 5'd0;
		end
		win_old = win_new;
		win_new = b;
		if (done) begin
			owe_word(1'b0, cfg_central[15:8], 1'b0);
			owe_word(1'b0, cfg_central[7:0], 1'b0);
			owe_word(1'b0, ECHO_TAG, 1'b0);
			owe_word(1'b0, spd, 1'b0);
			repeat (3) owe_word(1'b0, 8'h00, 1'b0);
			v = deadzone_speed(spd);
			if (held_sel[0])
				speed_pan = v;
			if (held_sel[1])
				speed_tilt = v;
			if (held_sel[2])
				speed_roll = v;
			ctrl = '{CTRL_HDR0, CTRL_HDR1, CTRL_HDR2, CTRL_HDR3,
				CTRL_MODE, CTRL_MODE, CTRL_MODE,
				speed_roll[7:0], speed_roll[15:8], 8'h00, 8'h00,
				speed_tilt[7:0], speed_tilt[15:8], 8'h00, 8'h00,
				speed_pan[7:0], speed_pan[15:8], 8'h00, 8'h00, 8'h00};
			sum = 8'h00;
			for (int k = 4; k < CTRL_LEN - 1; k++)
				sum = sum + ctrl[k];
			ctrl[CTRL_LEN - 1] = sum;
			for (int k = 0; k < CTRL_LEN; k++)
				owe_word(1'b1, ctrl[k], k == CTRL_LEN - 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pan = PAN_DEFAULT;
			cfg_tilt = TILT_DEFAULT;
			cfg_roll = ROLL_DEFAULT;
			cfg_central = CENTRAL_DEFAULT;
			win_old = 8'h00;
			win_new = 8'h00;
			rx_active = 1'b0;
			len_due = 8'h00;
			pay_count = 5'd0;
			first_pay = 8'h00;
			axis_sel = 3'b000;
			speed_pan = 16'h0000;
			speed_tilt = 16'h0000;
			speed_roll = 16'h0000;
			frames_due.delete();
			fails = 0;
			word_no = 0;
			fail_count <= 0;
			words_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PAN:     cfg_pan = pwdata[15:0];
					REG_TILT:    cfg_tilt = pwdata[15:0];
					REG_ROLL:    cfg_roll = pwdata[15:0];
					REG_CENTRAL: cfg_central = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				absorb_link_byte(rx_byte);
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: word %0d unexpected: link %0d byte %02h last %0d",
							$time, word_no, link, out_byte, last_of_run);
					fails++;
				end else begin
					want = frames_due.pop_front();
					if (want.link !== link || want.data !== out_byte ||
							want.last !== last_of_run) begin
						if (fails < 10)
							$display({"%0t: word %0d expected link %0d byte %02h last %0d,",
								" got link %0d byte %02h last %0d"}, $time, word_no,
								want.link, want.data, want.last,
								link, out_byte, last_of_run);
						fails++;
					end
				end
				word_no++;
			end
			fail_count <= fails;
			words_due <= frames_due.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the addressed speed command bridge: clock, reset, APB set-up,
// link stimulus and a stalling receiver. Needs ascb_pkg, the RTL and ascb_frame_checker.
module testbench;
	import ascb_pkg::*;

	localparam int unsigned MAX_PAYLOAD   = 5;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        link;
	logic [7:0]  out_byte;
	logic        last_of_run;

	int          fail_count;
	int          words_due;
	int unsigned cycle_count = 0;
	int          bytes_sent = 0;
	logic        tx_idle = 1'b1;
	logic        rx_idle = 1'b1;
	logic        hold_req = 1'b0;
	logic [15:0] axis_addr [3] = '{16'd6392, 16'd18251, 16'd25887};

	addressed_speed_command_bridge_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.link(link), .out_byte(out_byte), .last_of_run(last_of_run)
	);

	ascb_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) frame_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.link(link), .out_byte(out_byte), .last_of_run(last_of_run),
		.fail_count(fail_count), .words_due(words_due)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("addressed_speed_command_bridge_top regression: fail");
		$finish;
	end

	// receiver: random stalls per word, one long hold-off when asked
	initial begin
		logic hold_taken;
		int   stall;
		hold_taken = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = rx_idle ? $urandom_range(0, 3) : 0;
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// valid is only dropped when a gap is drawn, so it never toggles in one step
	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_command(input logic [15:0] addr, input logic [7:0] len,
			input int n_pay, input logic [7:0] speed);
		send_word(addr[15:8]);
		send_word(addr[7:0]);
		send_word(len);
		for (int k = 0; k < n_pay; k++)
			send_word(k == 0 ? speed : 8'($urandom));
	endtask

	// mostly well-formed commands; some noise, runaway lengths and cut-short payloads
	task automatic random_command();
		int          pick;
		logic [15:0] addr;
		logic [7:0]  len;
		int          n_pay;
		logic [7:0]  speed;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_word(8'($urandom));
			return;
		end
		addr = ($urandom_range(0, 99) < 85) ? axis_addr[$urandom_range(0, 2)] : 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 75)
			len = 8'($urandom_range(1, MAX_PAYLOAD));
		else if (pick < 85)
			len = 8'h00;
		else
			len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
		if (len >= 1 && len <= MAX_PAYLOAD)
			n_pay = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
		else
			n_pay = $urandom_range(0, MAX_PAYLOAD + 2);
		pick = $urandom_range(0, 7);
		speed = (pick == 0) ? 8'h7F : (pick == 1) ? 8'h80 : 8'($urandom);
		send_command(addr, len, n_pay, speed);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx != REG_CENTRAL)
			axis_addr[idx] = val;
	endtask

	// drain every owed word, then give the back end time to go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] shared;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset addresses; tilt match, then a completing word whose window holds roll
		send_command(axis_addr[1], 8'd3, 0, 8'h00);
		send_word(axis_addr[2][15:8]);
		send_word(axis_addr[2][7:0]);
		send_word(8'd2);
		send_word(8'h80);
		send_word(8'h00);
		// pan then tilt before completion: both selected, payload words past the first ignored
		send_word(axis_addr[0][15:8]);
		send_word(axis_addr[0][7:0]);
		send_word(axis_addr[1][15:8]);
		send_word(axis_addr[1][7:0]);
		send_word(8'd5);
		send_word(8'h7F);
		repeat (4) send_word(8'($urandom));
		// zero length runs away on the low byte of a pan address, which still starts a pan command
		send_command(axis_addr[2], 8'd0, 0, 8'h00);
		repeat (4) send_word(8'h00);
		send_word(axis_addr[0][15:8]);
		send_word(axis_addr[0][7:0]);
		send_word(8'd1);
		send_word(8'h00);
		settle();

		reg_write(REG_PAN, 16'h0000);
		reg_write(REG_TILT, 16'hFFFF);
		reg_write(REG_ROLL, 16'($urandom));
		reg_write(REG_CENTRAL, 16'hFFFF);
		while (bytes_sent < 130)
			random_command();
		settle();

		// all three axes on one address
		shared = 16'($urandom);
		reg_write(REG_PAN, shared);
		reg_write(REG_TILT, shared);
		reg_write(REG_ROLL, shared);
		reg_write(REG_CENTRAL, 16'h0000);
		send_command(shared, 8'd1, 1, 8'hFF);
		tx_idle = 1'b0;
		rx_idle <= 1'b0;
		while (bytes_sent < 175)
			random_command();
		tx_idle = 1'b1;
		rx_idle <= 1'b1;
		while (bytes_sent < 215)
			random_command();
		settle();

		// receiver holds off for a long stretch so the command queue fills
		reg_write(REG_PAN, 16'($urandom));
		reg_write(REG_TILT, 16'($urandom));
		reg_write(REG_ROLL, 16'($urandom));
		reg_write(REG_CENTRAL, 16'($urandom));
		hold_req <= 1'b1;
		while (bytes_sent < 320)
			random_command();
		settle();

		if (fail_count == 0 && words_due == 0)
			$display("addressed_speed_command_bridge_top regression: pass");
		else
			$display("addressed_speed_command_bridge_top regression: fail");
		$finish;
	end

endmodule

>>> files.f
rtl/ascb_pkg.sv
rtl/ascb_front.sv
rtl/ascb_queue.sv
rtl/ascb_back.sv
rtl/addressed_speed_command_bridge_top.sv
tb/sv/ascb_frame_checker.sv
tb/sv/testbench.sv
